>>> hw/rtl/sliding_window_request_rate_limiter_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window rate limiter
// Shared shorthand for clocked checks with and without the reset guard.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_REQUEST_RATE_LIMITER_DEFINES_SVH
`define SLIDING_WINDOW_REQUEST_RATE_LIMITER_DEFINES_SVH

// Clocked check, ignored while reset is asserted
`define SWRL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds across reset
`define SWRL_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/swrl_pkg.sv
// ----------------------------------------------------------------------------
// swrl_pkg
// Types, sizes and codes shared by the sliding window rate limiter files.
// ----------------------------------------------------------------------------
package swrl_pkg;

	// Slot log size and derived index widths
	localparam int STORE_DEPTH = 256;
	localparam int PTR_W       = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

	// Field widths
	localparam int NOW_W   = 63;
	localparam int TIME_W  = 64;
	localparam int IV_W    = 20;
	localparam int MAXR_W  = 9;
	localparam int DELAY_W = 32;
	localparam int CFG_W   = 20;

	localparam logic [TIME_W-1:0] WINDOW_US   = 64'd1000000;
	localparam logic [TIME_W-1:0] TIME_MAX    = {TIME_W{1'b1}};
	localparam logic [IV_W-1:0]   IV_RESET    = 20'd1000;

	typedef logic [NOW_W-1:0]   now_t;
	typedef logic [TIME_W-1:0]  time_t;
	typedef logic [DELAY_W-1:0] delay_t;

	// Configuration register indexes
	typedef enum logic [0:0] {
		CFG_MAX_REQUESTS  = 1'b0,
		CFG_SLOT_INTERVAL = 1'b1
	} cfg_idx_t;

	// Sequencer states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DIV_NOW,
		ST_ROUND,
		ST_PREP,
		ST_EXP_SCAN,
		ST_DECIDE,
		ST_RD_HEAD,
		ST_RD_LAST,
		ST_GOT_LAST,
		ST_DIV_GAP,
		ST_GAPFIX,
		ST_SETTLE,
		ST_FREE_SCAN,
		ST_SHIFT,
		ST_SHLAST,
		ST_PUT,
		ST_DONE
	} state_t;

endpackage

>>> hw/rtl/swrl_req_if.sv
// ----------------------------------------------------------------------------
// swrl_req_if
// Request channel: valid/ready handshake carrying the arrival time.
// ----------------------------------------------------------------------------
interface swrl_req_if;
	logic          valid;
	logic          ready;
	swrl_pkg::now_t now_us;

	modport source (output valid, output now_us, input ready);
	modport sink (input valid, input now_us, output ready);
endinterface

>>> hw/rtl/swrl_rsp_if.sv
// ----------------------------------------------------------------------------
// swrl_rsp_if
// Response channel: valid/ready handshake carrying the delay verdict.
// ----------------------------------------------------------------------------
interface swrl_rsp_if;
	logic             valid;
	logic             ready;
	swrl_pkg::delay_t delay_us;
	logic             delayed;
	logic             store_overflow;

	modport source (output valid, output delay_us, output delayed, output store_overflow,
		input ready);
	modport sink (input valid, input delay_us, input delayed, input store_overflow,
		output ready);
endinterface

>>> hw/rtl/swrl_ram.sv
// ----------------------------------------------------------------------------
// swrl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module swrl_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/sliding_window_request_rate_limiter.sv
// ----------------------------------------------------------------------------
// sliding_window_request_rate_limiter
// Sliding window log limiter: grants requests time slots in a log and reports a delay for each.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request per transfer with the arrival time now_us.
//   rsp returns one transfer per request: delay_us, delayed, store_overflow.
//   cfg_we/cfg_idx/cfg_wdata write max_requests and slot_interval_us; write
//   them only while no request is in flight.
//   Granted slot times live in a 256-entry ring in one RAM, kept sorted from
//   the head pointer. A request runs one at a time through a sequencer:
//   a bit-serial remainder division for rounding, a scan over the expired
//   entries, then either a scan for the first free slot followed by a
//   one-entry-per-cycle shift to open the insert place, or, when over the
//   rate, two head/tail reads and, if the tail is not below the head plus
//   the window, a second division. With limiting off (max_requests 0) a
//   request goes straight to the result. A new request is taken as soon as
//   the previous result sits in the output register, even while the
//   receiver stalls it.
//   Reset empties the log (count and head cleared), sets max_requests to 0
//   and slot_interval_us to 1000. A stalled receiver holds the result in the
//   output register; a finished next result waits until it is taken.
// ----------------------------------------------------------------------------
module sliding_window_request_rate_limiter (
	input  logic                            clk,
	input  logic                            arst_n,
	swrl_req_if.sink                        req,
	swrl_rsp_if.source                      rsp,
	input  logic                            cfg_we,
	input  swrl_pkg::cfg_idx_t              cfg_idx,
	input  logic [swrl_pkg::CFG_W-1:0]      cfg_wdata
);

	localparam int PW = swrl_pkg::PTR_W;
	localparam int CW = swrl_pkg::CNT_W;
	localparam int TW = swrl_pkg::TIME_W;
	localparam int IW = swrl_pkg::IV_W;
	localparam int MW = swrl_pkg::MAXR_W;
	localparam int DW = swrl_pkg::DELAY_W;
	localparam logic [CW-1:0] FULL = CW'(swrl_pkg::STORE_DEPTH);

	swrl_pkg::state_t state_q, state_d;

	logic [PW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [MW-1:0] maxr_q;
	logic [IW-1:0] ivcfg_q;
	logic [IW-1:0] iv;

	logic [swrl_pkg::NOW_W-1:0] now_q;
	logic [TW-1:0] div_q;
	logic [IW-1:0] rem_q;
	logic [5:0]    bit_q;
	logic [TW-1:0] rounded_q, expire_q, base_q, last_q, slot_q;
	logic [CW-1:0] pos_q, sj_q, wj_q;
	logic          vld_q, sv_q;
	logic [DW-1:0] dly_q;
	logic          dlyd_q, ovf_q;

	logic          rsp_v_q;
	logic [DW-1:0] rsp_dly_q;
	logic          rsp_dlyd_q, rsp_ovf_q;

	logic          mem_we;
	logic [PW-1:0] mem_waddr, mem_raddr;
	logic [TW-1:0] mem_wdata, mem_rdata;

	logic [IW:0]   div_try;
	logic [IW-1:0] rem_n;
	logic          exp_le, scan_last, rd_lt, rd_eq, over_rate, rsp_load;
	logic [TW:0]   base_sum, step_sum;
	logic [TW+1:0] gap_sum;
	logic [TW-1:0] diff;

	// Ring index: head plus offset, wrapped at the store depth
	function automatic logic [PW-1:0] phys(input logic [PW-1:0] head, input logic [CW-1:0] j);
		logic [CW:0] s;
		s = (CW+1)'(head) + (CW+1)'(j);
		if (s >= (CW+1)'(swrl_pkg::STORE_DEPTH)) begin
			s = s - (CW+1)'(swrl_pkg::STORE_DEPTH);
		end
		return s[PW-1:0];
	endfunction

	swrl_ram #(.WIDTH(TW), .DEPTH(swrl_pkg::STORE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Zero interval acts as one
	assign iv = (ivcfg_q == '0) ? IW'(1) : ivcfg_q;

	// One restoring remainder step per cycle
	assign div_try = {rem_q, div_q[TW-1]};
	assign rem_n = (div_try >= {1'b0, iv}) ? IW'(div_try - {1'b0, iv}) : div_try[IW-1:0];

	// Scan compares
	assign exp_le    = mem_rdata <= expire_q;
	assign scan_last = (pos_q + CW'(1)) == count_q;
	assign rd_lt     = mem_rdata < slot_q;
	assign rd_eq     = mem_rdata == slot_q;
	assign over_rate = (CW+MW)'(count_q) >= (CW+MW)'(maxr_q);
	assign base_sum  = {1'b0, mem_rdata} + {1'b0, swrl_pkg::WINDOW_US};
	assign step_sum  = {1'b0, slot_q} + (TW+1)'(iv);
	assign gap_sum   = {2'b00, last_q} + (TW+2)'(iv) - (TW+2)'(rem_q);
	assign diff      = slot_q - rounded_q;

	assign req.ready = state_q == swrl_pkg::ST_IDLE;
	assign rsp_load  = (state_q == swrl_pkg::ST_DONE) && (!rsp_v_q || rsp.ready);

	assign rsp.valid          = rsp_v_q;
	assign rsp.delay_us       = rsp_dly_q;
	assign rsp.delayed        = rsp_dlyd_q;
	assign rsp.store_overflow = rsp_ovf_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			swrl_pkg::ST_IDLE: begin
				if (req.valid) begin
					state_d = (maxr_q == '0) ? swrl_pkg::ST_DONE : swrl_pkg::ST_DIV_NOW;
				end
			end
			swrl_pkg::ST_DIV_NOW: begin
				if (bit_q == '0) state_d = swrl_pkg::ST_ROUND;
			end
			swrl_pkg::ST_ROUND: state_d = swrl_pkg::ST_PREP;
			swrl_pkg::ST_PREP: begin
				if (rounded_q >= swrl_pkg::WINDOW_US && count_q != '0) begin
					state_d = swrl_pkg::ST_EXP_SCAN;
				end else begin
					state_d = swrl_pkg::ST_DECIDE;
				end
			end
			swrl_pkg::ST_EXP_SCAN: begin
				if (vld_q && (!exp_le || scan_last)) state_d = swrl_pkg::ST_DECIDE;
			end
			swrl_pkg::ST_DECIDE: begin
				if (over_rate) begin
					state_d = swrl_pkg::ST_RD_HEAD;
				end else if (count_q == FULL) begin
					state_d = swrl_pkg::ST_DONE;
				end else if (count_q == '0) begin
					state_d = swrl_pkg::ST_PUT;
				end else begin
					state_d = swrl_pkg::ST_FREE_SCAN;
				end
			end
			swrl_pkg::ST_RD_HEAD: state_d = swrl_pkg::ST_RD_LAST;
			swrl_pkg::ST_RD_LAST: state_d = swrl_pkg::ST_GOT_LAST;
			swrl_pkg::ST_GOT_LAST: begin
				state_d = (mem_rdata < base_q) ? swrl_pkg::ST_SETTLE : swrl_pkg::ST_DIV_GAP;
			end
			swrl_pkg::ST_DIV_GAP: begin
				if (bit_q == '0) state_d = swrl_pkg::ST_GAPFIX;
			end
			swrl_pkg::ST_GAPFIX: state_d = swrl_pkg::ST_SETTLE;
			swrl_pkg::ST_SETTLE: begin
				if (count_q == FULL || slot_q == last_q) begin
					state_d = swrl_pkg::ST_DONE;
				end else begin
					state_d = swrl_pkg::ST_PUT;
				end
			end
			swrl_pkg::ST_FREE_SCAN: begin
				if (vld_q) begin
					if (rd_eq && slot_q == swrl_pkg::TIME_MAX) begin
						state_d = swrl_pkg::ST_DONE;
					end else if (rd_lt || rd_eq) begin
						if (scan_last) state_d = swrl_pkg::ST_PUT;
					end else begin
						state_d = swrl_pkg::ST_SHIFT;
					end
				end
			end
			swrl_pkg::ST_SHIFT: begin
				if (sj_q == pos_q) state_d = swrl_pkg::ST_SHLAST;
			end
			swrl_pkg::ST_SHLAST: state_d = swrl_pkg::ST_PUT;
			swrl_pkg::ST_PUT: state_d = swrl_pkg::ST_DONE;
			swrl_pkg::ST_DONE: begin
				if (rsp_load) state_d = swrl_pkg::ST_IDLE;
			end
			default: state_d = swrl_pkg::ST_IDLE;
		endcase
	end

	// RAM port control
	always_comb begin
		mem_raddr = phys(head_q, '0);
		mem_we    = 1'b0;
		mem_waddr = phys(head_q, pos_q);
		mem_wdata = slot_q;
		unique case (state_q) inside
			swrl_pkg::ST_EXP_SCAN, swrl_pkg::ST_FREE_SCAN: begin
				mem_raddr = phys(head_q, pos_q + CW'(vld_q));
			end
			swrl_pkg::ST_RD_LAST: mem_raddr = phys(head_q, count_q - CW'(1));
			swrl_pkg::ST_SHIFT: begin
				mem_raddr = phys(head_q, sj_q);
				mem_we    = sv_q;
				mem_waddr = phys(head_q, wj_q);
				mem_wdata = mem_rdata;
			end
			swrl_pkg::ST_SHLAST: begin
				mem_we    = 1'b1;
				mem_waddr = phys(head_q, wj_q);
				mem_wdata = mem_rdata;
			end
			swrl_pkg::ST_PUT: mem_we = 1'b1;
			default: mem_we = 1'b0;
		endcase
	end

	// Control state: sequencer, log pointers, config, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swrl_pkg::ST_IDLE;
			head_q  <= '0;
			count_q <= '0;
			maxr_q  <= '0;
			ivcfg_q <= swrl_pkg::IV_RESET;
			rsp_v_q <= 1'b0;
			vld_q   <= 1'b0;
			sv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_idx)
					swrl_pkg::CFG_MAX_REQUESTS:  maxr_q  <= cfg_wdata[MW-1:0];
					swrl_pkg::CFG_SLOT_INTERVAL: ivcfg_q <= cfg_wdata[IW-1:0];
					default: ;
				endcase
			end
			if (rsp_load) begin
				rsp_v_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_v_q <= 1'b0;
			end
			case (state_q) inside
				swrl_pkg::ST_PREP, swrl_pkg::ST_DECIDE: vld_q <= 1'b0;
				swrl_pkg::ST_EXP_SCAN: begin
					vld_q <= 1'b1;
					// drop the expired prefix
					if (vld_q && !exp_le) begin
						head_q  <= phys(head_q, pos_q);
						count_q <= count_q - pos_q;
					end else if (vld_q && scan_last) begin
						head_q  <= phys(head_q, count_q);
						count_q <= '0;
					end
				end
				swrl_pkg::ST_FREE_SCAN: begin
					vld_q <= 1'b1;
					sv_q  <= 1'b0;
				end
				swrl_pkg::ST_SHIFT: sv_q <= 1'b1;
				swrl_pkg::ST_PUT: count_q <= count_q + CW'(1);
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_dly_q  <= dly_q;
			rsp_dlyd_q <= dlyd_q;
			rsp_ovf_q  <= ovf_q;
		end
		case (state_q) inside
			swrl_pkg::ST_IDLE: begin
				now_q  <= req.now_us;
				div_q  <= {1'b0, req.now_us};
				rem_q  <= '0;
				bit_q  <= '1;
				dly_q  <= '0;
				dlyd_q <= 1'b0;
				ovf_q  <= 1'b0;
			end
			swrl_pkg::ST_DIV_NOW, swrl_pkg::ST_DIV_GAP: begin
				div_q <= {div_q[TW-2:0], 1'b0};
				rem_q <= rem_n;
				bit_q <= bit_q - 6'd1;
			end
			swrl_pkg::ST_ROUND: rounded_q <= {1'b0, now_q} - TW'(rem_q);
			swrl_pkg::ST_PREP: begin
				expire_q <= rounded_q - swrl_pkg::WINDOW_US;
				pos_q    <= '0;
			end
			swrl_pkg::ST_EXP_SCAN: begin
				if (vld_q && exp_le && !scan_last) pos_q <= pos_q + CW'(1);
			end
			swrl_pkg::ST_DECIDE: begin
				pos_q  <= '0;
				slot_q <= rounded_q;
				if (over_rate) begin
					dlyd_q <= 1'b1;
				end else if (count_q == FULL) begin
					ovf_q <= 1'b1;
				end
			end
			swrl_pkg::ST_RD_LAST: begin
				base_q <= base_sum[TW] ? swrl_pkg::TIME_MAX : base_sum[TW-1:0];
			end
			swrl_pkg::ST_GOT_LAST: begin
				last_q <= mem_rdata;
				slot_q <= base_q;
				div_q  <= mem_rdata - base_q;
				rem_q  <= '0;
				bit_q  <= '1;
			end
			swrl_pkg::ST_GAPFIX: begin
				slot_q <= (gap_sum[TW+1:TW] != 2'b00) ? swrl_pkg::TIME_MAX : gap_sum[TW-1:0];
			end
			swrl_pkg::ST_SETTLE: begin
				// saturate the delay to 32 bits
				dly_q <= (diff[TW-1:DW] != '0) ? '1 : diff[DW-1:0];
				ovf_q <= count_q == FULL;
				pos_q <= count_q;
			end
			swrl_pkg::ST_FREE_SCAN: begin
				if (vld_q) begin
					if (rd_eq && slot_q != swrl_pkg::TIME_MAX) begin
						slot_q <= step_sum[TW] ? swrl_pkg::TIME_MAX : step_sum[TW-1:0];
					end
					if (rd_lt || rd_eq) pos_q <= pos_q + CW'(1);
				end
				sj_q <= count_q - CW'(1);
			end
			swrl_pkg::ST_SHIFT: begin
				wj_q <= sj_q + CW'(1);
				if (sj_q != pos_q) sj_q <= sj_q - CW'(1);
			end
			default: ;
		endcase
	end

endmodule

>>> hw/rtl/swrl_checker.sv
// ----------------------------------------------------------------------------
// swrl_checker
// Port-level checks for the sliding window rate limiter, bound to the top.
// ----------------------------------------------------------------------------
`include "sliding_window_request_rate_limiter_defines.svh"

module swrl_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [swrl_pkg::DELAY_W-1:0] rsp_delay_us,
	input logic                         rsp_delayed
);

	// Hold a stalled response
	`SWRL_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")
	`SWRL_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_delay_us), "delay changed while stalled")
	// One request in work at a time
	`SWRL_ASSERT(a_one_busy, req_valid && req_ready |=> !req_ready, "request taken while busy")
	// An undelayed request never reports a wait
	`SWRL_ASSERT(a_no_wait, rsp_valid && !rsp_delayed |-> rsp_delay_us == '0, "undelayed result with delay")
	// Reset leaves no response pending
	`SWRL_ASSERT_ALWAYS(a_rst_idle, !arst_n |-> !rsp_valid, "response valid in reset")

endmodule

bind sliding_window_request_rate_limiter swrl_checker u_swrl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_delay_us (rsp.delay_us),
	.rsp_delayed  (rsp.delayed)
);
